>>> hw/rtl/rpci_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpci_pkg
// Shared types and constants for the rigid pose compose / invert pipeline.
// ---------------------------------------------------------------------------
package rpci_pkg;

	typedef enum logic {
		OP_COMPOSE = 1'b0,
		OP_INVERT  = 1'b1
	} op_t;

	// Packed quaternion layout: four 16-bit lanes, w in the lowest.
	localparam int LANE_W = 16;
	localparam int LANE_N = 4;
	localparam int QUAT_BITS = LANE_W * LANE_N;

	// Hamilton product a*b: output o, term n uses a[n] * b[HAM_B[o][n]],
	// subtracted where HAM_NEG[o][n] is set.
	localparam int HAM_B [LANE_N][LANE_N] = '{
		'{0, 1, 2, 3},
		'{1, 0, 3, 2},
		'{2, 3, 0, 1},
		'{3, 2, 1, 0}
	};
	localparam bit HAM_NEG [LANE_N][LANE_N] = '{
		'{1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0}
	};

endpackage

>>> hw/rtl/rpci_hamilton.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpci_hamilton
// Two-stage quaternion product with rounding and lane saturation; passes the
// conjugate through saturation when the item is an inversion.
// ---------------------------------------------------------------------------
module rpci_hamilton #(
	parameter int QUAT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          op_inv,
	input  logic signed [QUAT_WIDTH:0]    qa [rpci_pkg::LANE_N],
	input  logic signed [QUAT_WIDTH-1:0]  qb [rpci_pkg::LANE_N],
	output logic [rpci_pkg::QUAT_BITS-1:0] quat
);
	import rpci_pkg::*;

	localparam int QE  = QUAT_WIDTH + 1;
	localparam int QF  = QUAT_WIDTH - 2;
	localparam int HP  = 2 * QE;
	localparam int HSW = HP + 3;
	localparam int HALF = 1 << (QF - 1);

	logic signed [HP-1:0] prod_s2 [LANE_N][LANE_N];
	logic signed [QE-1:0] conj_s2 [LANE_N];
	logic                 inv_s2;
	logic [QUAT_BITS-1:0] quat_s3;

	function automatic logic [LANE_W-1:0] sat_lane(input logic signed [HSW-1:0] x);
		logic signed [QUAT_WIDTH-1:0] y;
		if (x[HSW-1:QUAT_WIDTH-1] == '0 || x[HSW-1:QUAT_WIDTH-1] == '1) begin
			y = x[QUAT_WIDTH-1:0];
		end else if (x[HSW-1]) begin
			y = {1'b1, {(QUAT_WIDTH-1){1'b0}}};
		end else begin
			y = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
		end
		return LANE_W'(y);
	endfunction

	// Stage 2: all sixteen lane products.
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s2 <= op_inv;
			for (int o = 0; o < LANE_N; o++) begin
				conj_s2[o] <= qa[o];
				for (int n = 0; n < LANE_N; n++) begin
					prod_s2[o][n] <= HP'(qa[n]) * HP'(qb[HAM_B[o][n]]);
				end
			end
		end
	end

	// Stage 3: signed sums, round half up, saturate each lane.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int o = 0; o < LANE_N; o++) begin
				logic signed [HSW-1:0] acc;
				acc = HSW'(HALF);
				for (int n = 0; n < LANE_N; n++) begin
					if (HAM_NEG[o][n]) acc = acc - HSW'(prod_s2[o][n]);
					else               acc = acc + HSW'(prod_s2[o][n]);
				end
				if (inv_s2) quat_s3[LANE_W*o +: LANE_W] <= sat_lane(HSW'(conj_s2[o]));
				else        quat_s3[LANE_W*o +: LANE_W] <= sat_lane(acc >>> QF);
			end
		end
	end

	assign quat = quat_s3;

endmodule

>>> hw/rtl/rigid_pose_compose_invert.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rigid_pose_compose_invert
// Rigid pose composition (A then B) and inversion of A, Q16.16 positions and
// Q1.14 quaternions, five-stage pipeline with saturating outputs.
// ---------------------------------------------------------------------------
// Each input transfer is registered through stages 1 to 5 in order.
// Throughput: one item per cycle through the five-stage pipeline unless the output stalls.
// A stall at the output freezes every stage together; nothing drops.
// Reset (arst_n low) clears only the stage valid bits; data is not reset.
// POS_WIDTH may range 16..32 for the 32-bit position ports.
module rigid_pose_compose_invert #(
	parameter int POS_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [31:0]                    a_x,
	input  logic [31:0]                    a_y,
	input  logic [31:0]                    a_z,
	input  logic [rpci_pkg::QUAT_BITS-1:0] a_quat,
	input  logic [31:0]                    b_x,
	input  logic [31:0]                    b_y,
	input  logic [31:0]                    b_z,
	input  logic [rpci_pkg::QUAT_BITS-1:0] b_quat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    res_x,
	output logic [31:0]                    res_y,
	output logic [31:0]                    res_z,
	output logic [rpci_pkg::QUAT_BITS-1:0] res_quat
);
	import rpci_pkg::*;

	// Widths: VE holds a negated position, QE a negated lane.
	localparam int QF  = QUAT_WIDTH - 2;
	localparam int QE  = QUAT_WIDTH + 1;
	localparam int VE  = POS_WIDTH + 1;
	localparam int P1  = VE + QE;
	localparam int SW1 = P1 + 2;
	localparam int TW  = POS_WIDTH + 6;
	localparam int P2  = TW + QE;
	localparam int SW2 = P2 + 3;
	localparam int RW  = POS_WIDTH + 12;
	localparam int HALF1 = 1 << (QF - 2);
	localparam int HALF2 = 1 << (QF - 1);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [31:0] a_pos [3];
	logic [31:0] b_pos [3];

	// Stage 1: decoded operands.
	logic                          inv_s1;
	logic signed [VE-1:0]          v_s1  [3];
	logic signed [POS_WIDTH-1:0]   pa_s1 [3];
	logic signed [QE-1:0]          q_s1  [LANE_N];
	logic signed [QUAT_WIDTH-1:0]  qb_s1 [LANE_N];

	// Stage 2: cross-product terms for t = 2 (qv x v).
	logic                          inv_s2;
	logic signed [P1-1:0]          m0_s2 [3];
	logic signed [P1-1:0]          m1_s2 [3];
	logic signed [VE-1:0]          v_s2  [3];
	logic signed [POS_WIDTH-1:0]   pa_s2 [3];
	logic signed [QE-1:0]          q_s2  [LANE_N];

	// Stage 3: rounded t.
	logic                          inv_s3;
	logic signed [TW-1:0]          t_s3  [3];
	logic signed [VE-1:0]          v_s3  [3];
	logic signed [POS_WIDTH-1:0]   pa_s3 [3];
	logic signed [QE-1:0]          q_s3  [LANE_N];
	logic [QUAT_BITS-1:0]          quat_s3;

	// Stage 4: w*t and qv x t terms.
	logic                          inv_s4;
	logic signed [P2-1:0]          n_s4  [3][3];
	logic signed [VE-1:0]          v_s4  [3];
	logic signed [POS_WIDTH-1:0]   pa_s4 [3];
	logic [QUAT_BITS-1:0]          quat_s4;

	// Stage 5: saturated result.
	logic signed [POS_WIDTH-1:0]   pos_s5 [3];
	logic [QUAT_BITS-1:0]          quat_s5;

	assign a_pos[0] = a_x;
	assign a_pos[1] = a_y;
	assign a_pos[2] = a_z;
	assign b_pos[0] = b_x;
	assign b_pos[1] = b_y;
	assign b_pos[2] = b_z;

	// Advance the whole pipe unless a finished result is held at the output.
	assign en       = !vld_s5 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: pick the vector to rotate and the rotation quaternion.
	// Inversion rotates -pA by the conjugate of qA.
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= (op_t'(opcode) == OP_INVERT);
			for (int i = 0; i < 3; i++) begin
				logic signed [VE-1:0] pa_e;
				logic signed [VE-1:0] pb_e;
				pa_e = VE'($signed(a_pos[i][POS_WIDTH-1:0]));
				pb_e = VE'($signed(b_pos[i][POS_WIDTH-1:0]));
				pa_s1[i] <= $signed(a_pos[i][POS_WIDTH-1:0]);
				v_s1[i]  <= (op_t'(opcode) == OP_INVERT) ? -pa_e : pb_e;
			end
			for (int l = 0; l < LANE_N; l++) begin
				logic signed [QE-1:0] qa_e;
				qa_e = QE'($signed(a_quat[LANE_W*l +: QUAT_WIDTH]));
				q_s1[l]  <= (op_t'(opcode) == OP_INVERT && l != 0) ? -qa_e : qa_e;
				qb_s1[l] <= $signed(b_quat[LANE_W*l +: QUAT_WIDTH]);
			end
		end
	end

	// Stage 2: cross-product multiplies.
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s2 <= inv_s1;
			for (int i = 0; i < 3; i++) begin
				m0_s2[i] <= P1'(v_s1[(i + 2) % 3]) * P1'(q_s1[1 + (i + 1) % 3]);
				m1_s2[i] <= P1'(v_s1[(i + 1) % 3]) * P1'(q_s1[1 + (i + 2) % 3]);
				v_s2[i]  <= v_s1[i];
				pa_s2[i] <= pa_s1[i];
			end
			for (int l = 0; l < LANE_N; l++) q_s2[l] <= q_s1[l];
		end
	end

	// Quaternion path runs alongside stages 2 and 3.
	rpci_hamilton #(
		.QUAT_WIDTH (QUAT_WIDTH)
	) u_ham (
		.clk    (clk),
		.en     (en),
		.op_inv (inv_s1),
		.qa     (q_s1),
		.qb     (qb_s1),
		.quat   (quat_s3)
	);

	// Stage 3: t = 2 (qv x v), one rounding at position scale.
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s3 <= inv_s2;
			for (int i = 0; i < 3; i++) begin
				logic signed [SW1-1:0] s;
				s = SW1'(m0_s2[i]) - SW1'(m1_s2[i]) + SW1'(HALF1);
				t_s3[i]  <= TW'(s >>> (QF - 1));
				v_s3[i]  <= v_s2[i];
				pa_s3[i] <= pa_s2[i];
			end
			for (int l = 0; l < LANE_N; l++) q_s3[l] <= q_s2[l];
		end
	end

	// Stage 4: w*t + qv x t multiplies.
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s4  <= inv_s3;
			quat_s4 <= quat_s3;
			for (int i = 0; i < 3; i++) begin
				n_s4[i][0] <= P2'(t_s3[i]) * P2'(q_s3[0]);
				n_s4[i][1] <= P2'(t_s3[(i + 2) % 3]) * P2'(q_s3[1 + (i + 1) % 3]);
				n_s4[i][2] <= P2'(t_s3[(i + 1) % 3]) * P2'(q_s3[1 + (i + 2) % 3]);
				v_s4[i]    <= v_s3[i];
				pa_s4[i]   <= pa_s3[i];
			end
		end
	end

	// Stage 5: round, add v and (for compose) pA, saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			quat_s5 <= quat_s4;
			for (int i = 0; i < 3; i++) begin
				logic signed [SW2-1:0] s;
				logic signed [RW-1:0]  r;
				s = SW2'(n_s4[i][0]) + SW2'(n_s4[i][1]) - SW2'(n_s4[i][2])
					+ SW2'(HALF2);
				r = RW'(s >>> QF) + RW'(v_s4[i]);
				if (!inv_s4) r = r + RW'(pa_s4[i]);
				if (r[RW-1:POS_WIDTH-1] == '0 || r[RW-1:POS_WIDTH-1] == '1) begin
					pos_s5[i] <= r[POS_WIDTH-1:0];
				end else if (r[RW-1]) begin
					pos_s5[i] <= {1'b1, {(POS_WIDTH-1){1'b0}}};
				end else begin
					pos_s5[i] <= {1'b0, {(POS_WIDTH-1){1'b1}}};
				end
			end
		end
	end

	assign out_valid = vld_s5;
	assign res_x     = 32'(pos_s5[0]);
	assign res_y     = 32'(pos_s5[1]);
	assign res_z     = 32'(pos_s5[2]);
	assign res_quat  = quat_s5;

endmodule

>>> hw/rtl/rpci_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpci_checker
// Port-level checks for the pose pipeline, bound to the top level.
// ---------------------------------------------------------------------------
module rpci_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [rpci_pkg::QUAT_BITS-1:0] res_quat
);
	import rpci_pkg::*;

	// An empty output stage always takes a new item.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while output empty");

	// A held result freezes the pipe, so the input must not take a transfer.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input ready while output stalled");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped during stall");

	a_quat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(res_quat))
		else $error("result changed during stall");

endmodule

bind rigid_pose_compose_invert rpci_checker u_rpci_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.res_quat  (res_quat)
);

>>> tb/sv/tb_rigid_pose_compose_invert.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rigid_pose_compose_invert
// Self-checking bench for the rigid pose compose / invert pipeline.
// A short table of hand-picked poses is followed by random pose pairs. An
// exact-arithmetic pose predictor supplies every expected result that is not
// typed into the table. The sender idles in bursts and the receiver stalls on
// a rotating pattern of its own.
// ---------------------------------------------------------------------------
module tb_rigid_pose_compose_invert;
	import rpci_pkg::*;

	localparam int   N_RANDOM   = 1900;
	localparam int   IDLE_LIMIT = 2000;
	localparam int   DRAIN_CYC  = 12;
	localparam int   POS_W      = 32;
	localparam int   QW         = 16;
	localparam int   QFRAC      = QW - 2;
	localparam logic [15:0] Q_ONE = 16'h4000;
	localparam logic [63:0] Q_IDENT = {48'h0, Q_ONE};

	typedef logic signed [127:0] wide_t;

	typedef struct {
		op_t         op;
		logic [31:0] ax, ay, az;
		logic [63:0] aq;
		logic [31:0] bx, by, bz;
		logic [63:0] bq;
	} pose_pair_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic [63:0] q;
	} pose_res_t;

	typedef struct {
		pose_pair_t stim;
		bit         typed;
		pose_res_t  res;
	} table_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = 1'b0;
	logic [31:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
	logic [63:0] a_quat = '0, b_quat = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] res_x, res_y, res_z;
	logic [63:0] res_quat;

	pose_res_t expected_poses[$];
	int        errors = 0;
	int        idle_cycles = 0;
	int        burst_left = 8;
	int        stall_cyc = 0;

	rigid_pose_compose_invert dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_quat(a_quat),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_quat(b_quat),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_x(res_x), .res_y(res_y), .res_z(res_z), .res_quat(res_quat)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Pose predictor. Every sum is formed exactly in a wide signed value and
	// rounded once, half up; only the final position and lanes saturate.
	// ---------------------------------------------------------------------
	function automatic wide_t round_down_by(wide_t s, int sh);
		wide_t half;
		half = wide_t'(1) <<< (sh - 1);
		return (s + half) >>> sh;
	endfunction

	function automatic wide_t clamp(wide_t v, int w);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic wide_t lane_of(logic [63:0] q, int n);
		logic signed [15:0] l;
		l = q[16*n +: 16];
		return wide_t'(l);
	endfunction

	// Rotate v by quaternion q with the two-cross-product form.
	function automatic void rotate_by(input wide_t q[4], inout wide_t v[3]);
		wide_t t[3];
		wide_t r[3];
		int j, k;
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			t[i] = round_down_by(v[k] * q[1+j] - v[j] * q[1+k], QFRAC - 1);
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			r[i] = v[i] + round_down_by(t[i] * q[0] + t[k] * q[1+j] - t[j] * q[1+k], QFRAC);
		end
		v = r;
	endfunction

	function automatic pose_res_t predict_pose(pose_pair_t p);
		wide_t qa[4], qb[4], qr[4], v[3], pa[3], sum;
		pose_res_t r;
		logic [31:0] ta[3], tb[3];
		ta = '{p.ax, p.ay, p.az};
		tb = '{p.bx, p.by, p.bz};
		for (int n = 0; n < 4; n++) begin
			qa[n] = lane_of(p.aq, n);
			qb[n] = lane_of(p.bq, n);
		end
		for (int i = 0; i < 3; i++) pa[i] = wide_t'(signed'(ta[i]));
		if (p.op == OP_COMPOSE) begin
			for (int i = 0; i < 3; i++) v[i] = wide_t'(signed'(tb[i]));
			rotate_by(qa, v);
			for (int i = 0; i < 3; i++) v[i] = v[i] + pa[i];
			for (int o = 0; o < 4; o++) begin
				sum = 0;
				for (int m = 0; m < 4; m++)
					if (HAM_NEG[o][m]) sum = sum - qa[m] * qb[HAM_B[o][m]];
					else sum = sum + qa[m] * qb[HAM_B[o][m]];
				qr[o] = round_down_by(sum, QFRAC);
			end
		end else begin
			// Conjugate A, then rotate the negated position by it.
			qr[0] = qa[0];
			for (int n = 1; n < 4; n++) qr[n] = -qa[n];
			for (int i = 0; i < 3; i++) v[i] = -pa[i];
			rotate_by(qr, v);
		end
		r.x = 32'(clamp(v[0], POS_W));
		r.y = 32'(clamp(v[1], POS_W));
		r.z = 32'(clamp(v[2], POS_W));
		for (int n = 0; n < 4; n++) r.q[16*n +: 16] = 16'(clamp(qr[n], QW));
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic pose_pair_t mk_pair(op_t op, logic [31:0] ax, ay, az,
			logic [63:0] aq, logic [31:0] bx, by, bz, logic [63:0] bq);
		pose_pair_t p;
		p.op = op;
		p.ax = ax; p.ay = ay; p.az = az; p.aq = aq;
		p.bx = bx; p.by = by; p.bz = bz; p.bq = bq;
		return p;
	endfunction

	function automatic pose_res_t mk_res(logic [31:0] x, y, z, logic [63:0] q);
		pose_res_t r;
		r.x = x; r.y = y; r.z = z; r.q = q;
		return r;
	endfunction

	// Mix full-range, moderate, small and extreme positions.
	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
			3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'hffff_ffff;
					default: return 32'h0;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	function automatic logic [15:0] rand_lane();
		case ($urandom_range(0, 4))
			0, 1: return 16'($urandom);
			2: return 16'($signed($urandom_range(0, 16384)) - 8192);
			3: begin
				case ($urandom_range(0, 3))
					0: return 16'h7fff;
					1: return 16'h8000;
					2: return Q_ONE;
					default: return 16'hc000;
				endcase
			end
			default: return 16'($signed($urandom_range(0, 200)) - 100);
		endcase
	endfunction

	// One draw in three is a near-unit attitude; the rest are raw lane mixes.
	function automatic logic [63:0] rand_quat();
		logic [63:0] q;
		for (int n = 0; n < 4; n++) q[16*n +: 16] = rand_lane();
		if ($urandom_range(0, 2) == 0)
			q = {16'($signed($urandom_range(0, 64)) - 32), 16'($signed($urandom_range(0, 64)) - 32),
				16'($signed($urandom_range(0, 12000)) - 6000), 16'(16384 - $urandom_range(0, 6000))};
		return q;
	endfunction

	// Present one pose pair and hold it until the transfer; then record the
	// expected result and idle for a random gap when the burst runs out.
	task automatic send_pair(pose_pair_t p, bit typed, pose_res_t r);
		opcode <= p.op;
		a_x <= p.ax; a_y <= p.ay; a_z <= p.az; a_quat <= p.aq;
		b_x <= p.bx; b_y <= p.by; b_z <= p.bz; b_quat <= p.bq;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_poses.push_back(typed ? r : predict_pose(p));
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// ---------------------------------------------------------------------
	// Receiver: rotate between always ready, coin-flip, mostly stalled and
	// a regular on/off pattern, chosen by bits 8:7 of the stall counter.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		stall_cyc <= stall_cyc + 1;
		if (arst_n) begin
			case (stall_cyc[8:7])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= stall_cyc[2];
			endcase
		end
	end

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		pose_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_poses.size() == 0) begin
				report("unexpected result", res_quat, 64'h0);
			end else begin
				want = expected_poses.pop_front();
				if (res_x !== want.x) report("res_x", 64'(res_x), 64'(want.x));
				if (res_y !== want.y) report("res_y", 64'(res_y), 64'(want.y));
				if (res_z !== want.z) report("res_z", 64'(res_z), 64'(want.z));
				if (res_quat !== want.q) report("res_quat", res_quat, want.q);
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		table_row_t rows[$];
		table_row_t row;
		pose_res_t none;
		none = mk_res('0, '0, '0, '0);

		// Identity attitude for A: B's position just adds, B's attitude passes.
		rows.push_back('{mk_pair(OP_COMPOSE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, Q_IDENT,
			32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 64'h1234_8000_7fff_c000), 1'b1,
			mk_res(32'h0005_0000, 32'h0007_0000, 32'h0009_0000, 64'h1234_8000_7fff_c000)});
		// Position sums that saturate at both ends.
		rows.push_back('{mk_pair(OP_COMPOSE, 32'h7fff_ffff, 32'h8000_0000, 32'h0, Q_IDENT,
			32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, Q_IDENT), 1'b1,
			mk_res(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, Q_IDENT)});
		// Inverting the most negative position saturates only at the end.
		rows.push_back('{mk_pair(OP_INVERT, 32'h8000_0000, 32'h7fff_ffff, 32'h0, Q_IDENT,
			32'hdead_beef, 32'h1, 32'h2, 64'hffff_ffff_ffff_ffff), 1'b1,
			mk_res(32'h7fff_ffff, 32'h8000_0001, 32'h0, Q_IDENT)});
		// Zero attitude: rotation vanishes, product is zero.
		rows.push_back('{mk_pair(OP_COMPOSE, 32'h0, 32'h0, 32'h0, 64'h0,
			32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 64'h7fff_7fff_7fff_7fff), 1'b1,
			mk_res(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 64'h0)});
		// The rest go through the predictor: extreme lanes, non-unit attitudes,
		// B ignored on inversion, all-ones fields.
		rows.push_back('{mk_pair(OP_INVERT, 32'h1, 32'h2, 32'h3, 64'h8000_8000_8000_8000,
			'0, '0, '0, '0), 1'b0, none});
		rows.push_back('{mk_pair(OP_INVERT, 32'h1, 32'h2, 32'h3, 64'h8000_8000_8000_8000,
			32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 64'hffff_0000_ffff_0000), 1'b0, none});
		rows.push_back('{mk_pair(OP_COMPOSE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			64'h7fff_7fff_7fff_7fff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			64'h7fff_7fff_7fff_7fff), 1'b0, none});
		rows.push_back('{mk_pair(OP_COMPOSE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			64'h8000_8000_8000_8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			64'h8000_8000_8000_8000), 1'b0, none});
		rows.push_back('{mk_pair(OP_COMPOSE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			64'hffff_ffff_ffff_ffff), 1'b0, none});
		// Quarter turn about z applied to a unit x offset.
		rows.push_back('{mk_pair(OP_COMPOSE, 32'h0, 32'h0, 32'h0, 64'h2d41_0000_0000_2d41,
			32'h0001_0000, 32'h0, 32'h0, 64'h2d41_0000_0000_2d41), 1'b0, none});
		rows.push_back('{mk_pair(OP_INVERT, 32'h0001_0000, 32'h0, 32'h0, 64'h2d41_0000_0000_2d41,
			'0, '0, '0, '0), 1'b0, none});
		rows.push_back('{mk_pair(OP_COMPOSE, 32'h0000_8000, 32'hffff_8000, 32'h1,
			64'h0000_4000_0000_0000, 32'h0003_0001, 32'hfffc_ffff, 32'h7fff_0000,
			64'h4000_0000_c000_4000), 1'b0, none});
		rows.push_back('{mk_pair(OP_INVERT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			64'h7fff_8000_7fff_8000, '0, '0, '0, '0), 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			send_pair(row.stim, row.typed, row.res);
		end

		for (int n = 0; n < N_RANDOM; n++)
			send_pair(mk_pair(op_t'($urandom_range(0, 1)), rand_pos(), rand_pos(), rand_pos(),
				rand_quat(), rand_pos(), rand_pos(), rand_pos(), rand_quat()), 1'b0, none);

		// Drain the pipeline, then keep watching the output for strays.
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/rpci_pkg.sv
hw/rtl/rpci_hamilton.sv
hw/rtl/rigid_pose_compose_invert.sv
hw/rtl/rpci_checker.sv
tb/sv/tb_rigid_pose_compose_invert.sv
